// ===== src/fdsg_pkg.sv =====
// Shared types and constants of the filled disk span generator.
`timescale 1ns / 1ps

package fdsg_pkg;

    localparam int MAX_RADIUS  = 48;
    localparam int COORD_BITS  = 11;

    localparam int CENTER_W    = 11;
    localparam int RADIUS_W    = 6;
    localparam int COLOR_W     = 32;
    localparam int WIDTH_W     = 12;
    localparam int ADDR_W      = 23;
    localparam int LEN_W       = 7;
    localparam int ERR_W       = 16;
    localparam int CNT_W       = 7;
    localparam int MAX_RESULTS = 64;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_C,
        ST_MUL_R,
        ST_EMIT_A,
        ST_EMIT_B
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul_c;
        logic mul_r;
        logic emit_a;
        logic emit_b;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic take_b;
        logic a_last;
        logic b_last;
    } t_sts;

endpackage

// ===== src/filled_disk_span_generator_core.sv =====
// Top level of the filled disk span generator.
`timescale 1ns / 1ps

// Takes one disk request (center, radius, color) and walks the midpoint circle
// algorithm, emitting span pairs: linear start addresses (row * image_width +
// column, wrapped to 23 bits) for the rows above and below the center, the span
// length (twice the half width, right edge excluded) and the color; last_span
// marks the final pair of a disk. Radius saturates at P_MAX_RADIUS. A request
// is first latched, then the center row and radius row products are formed in
// one shared multiplier; after that one span pair is emitted per cycle while the
// output is not stalled; a radius r gives at most r + 2 pairs. The next request
// is taken once the last pair of the current one has been loaded into the
// output register. image_width may be written any time the block is idle.
module filled_disk_span_generator_core #(
    parameter int P_MAX_RADIUS = fdsg_pkg::MAX_RADIUS,
    parameter int P_COORD_BITS = fdsg_pkg::COORD_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic        [fdsg_pkg::WIDTH_W-1:0]  i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic        [fdsg_pkg::CENTER_W-1:0] i_center_x,
    input  logic        [fdsg_pkg::CENTER_W-1:0] i_center_y,
    input  logic        [fdsg_pkg::RADIUS_W-1:0] i_radius,
    input  logic        [fdsg_pkg::COLOR_W-1:0]  i_fill_color,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [fdsg_pkg::ADDR_W-1:0]   o_upper_start_address,
    output logic signed [fdsg_pkg::ADDR_W-1:0]   o_lower_start_address,
    output logic        [fdsg_pkg::LEN_W-1:0]    o_span_length,
    output logic        [fdsg_pkg::COLOR_W-1:0]  o_span_color,
    output logic                                 o_last_span
);

    fdsg_pkg::t_cmd cmd;
    fdsg_pkg::t_sts sts;
    logic           busy;

    fdsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    fdsg_dp #(
        .MAX_RADIUS (P_MAX_RADIUS),
        .COORD_BITS (P_COORD_BITS)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_sts                 (sts),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_center_x            (i_center_x),
        .i_center_y            (i_center_y),
        .i_radius              (i_radius),
        .i_fill_color          (i_fill_color),
        .i_out_stall           (i_out_stall),
        .o_out_valid           (o_out_valid),
        .o_upper_start_address (o_upper_start_address),
        .o_lower_start_address (o_lower_start_address),
        .o_span_length         (o_span_length),
        .o_span_color          (o_span_color),
        .o_last_span           (o_last_span)
    );

    assign o_in_stall = busy;

endmodule

// ===== src/fdsg_dp.sv =====
// Datapath: disk request latch, midpoint stepping, address arithmetic and output register.
`timescale 1ns / 1ps

module fdsg_dp #(
    parameter int MAX_RADIUS = fdsg_pkg::MAX_RADIUS,
    parameter int COORD_BITS = fdsg_pkg::COORD_BITS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  fdsg_pkg::t_cmd                           i_cmd,
    output fdsg_pkg::t_sts                           o_sts,
    input  logic                                     i_cfg_we,
    input  logic        [fdsg_pkg::WIDTH_W-1:0]      i_cfg_wdata,
    input  logic        [fdsg_pkg::CENTER_W-1:0]     i_center_x,
    input  logic        [fdsg_pkg::CENTER_W-1:0]     i_center_y,
    input  logic        [fdsg_pkg::RADIUS_W-1:0]     i_radius,
    input  logic        [fdsg_pkg::COLOR_W-1:0]      i_fill_color,
    input  logic                                     i_out_stall,
    output logic                                     o_out_valid,
    output logic signed [fdsg_pkg::ADDR_W-1:0]       o_upper_start_address,
    output logic signed [fdsg_pkg::ADDR_W-1:0]       o_lower_start_address,
    output logic        [fdsg_pkg::LEN_W-1:0]        o_span_length,
    output logic        [fdsg_pkg::COLOR_W-1:0]      o_span_color,
    output logic                                     o_last_span
);

    localparam int CW = (COORD_BITS < fdsg_pkg::CENTER_W) ? COORD_BITS : fdsg_pkg::CENTER_W;
    localparam int SW = $clog2(MAX_RADIUS + 2) + 1;
    localparam int MW = (CW > SW) ? CW : SW;
    localparam int AW = fdsg_pkg::ADDR_W;
    localparam int EW = fdsg_pkg::ERR_W;
    localparam int NW = fdsg_pkg::CNT_W;
    localparam int LW = fdsg_pkg::LEN_W;
    localparam int RW = fdsg_pkg::RADIUS_W;

    logic        [fdsg_pkg::WIDTH_W-1:0] r_width;
    logic        [CW-1:0]                r_cx;
    logic        [CW-1:0]                r_cy;
    logic        [fdsg_pkg::COLOR_W-1:0] r_color;
    logic signed [SW-1:0]                r_x;
    logic signed [SW-1:0]                r_y;
    logic signed [EW-1:0]                r_err;
    logic        [NW-1:0]                r_n;
    logic        [AW-1:0]                r_base;
    logic        [AW-1:0]                r_xw;
    logic        [AW-1:0]                r_yw;

    logic                                r_out_valid;
    logic        [AW-1:0]                r_upper;
    logic        [AW-1:0]                r_lower;
    logic        [LW-1:0]                r_len;
    logic        [fdsg_pkg::COLOR_W-1:0] r_out_color;
    logic                                r_last;

    logic        [RW-1:0]                rad_sat;
    logic        [MW-1:0]                mul_a;
    logic        [MW+fdsg_pkg::WIDTH_W-1:0] mul_p;
    logic        [AW-1:0]                mul_ext;
    logic        [AW-1:0]                w_ext;

    logic signed [EW-1:0]                y_e;
    logic signed [EW-1:0]                x_e;
    logic signed [EW-1:0]                e1;
    logic signed [EW-1:0]                d1;
    logic signed [EW-1:0]                e_dec;
    logic signed [EW-1:0]                e_b;
    logic                                cond;
    logic        [NW-1:0]                n1;
    logic                                room1;
    logic signed [SW-1:0]                y1;
    logic signed [SW-1:0]                y_m1;
    logic signed [SW-1:0]                x_dec;
    logic signed [SW-1:0]                x_aft;
    logic signed [SW:0]                  cmp_a;
    logic signed [SW:0]                  cmp_b;
    logic                                take_b;
    logic                                a_last;
    logic                                b_last;

    logic        [AW-1:0]                dyw;
    logic signed [SW-1:0]                half;
    logic        [AW-1:0]                col;
    logic                                out_free;

    assign rad_sat = (i_radius > RW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : i_radius;

    // One multiplier, shared between the center row and the radius row.
    assign mul_a   = i_cmd.mul_c ? MW'(r_cy) : MW'(unsigned'(r_x));
    assign mul_p   = mul_a * r_width;
    assign mul_ext = AW'(mul_p);
    assign w_ext   = AW'(r_width);

    // Midpoint step decision for the current x, y.
    assign y_e   = EW'(r_y);
    assign x_e   = EW'(r_x);
    assign e1    = r_err + (y_e <<< 1) + EW'(3);
    assign d1    = e1 - x_e;
    assign cond  = !d1[EW-1];
    assign e_dec = e1 + EW'(3) - (x_e <<< 1);
    assign e_b   = r_err + EW'(3) - (x_e <<< 1);

    assign n1     = r_n + 1'b1;
    assign room1  = n1 < NW'(fdsg_pkg::MAX_RESULTS);
    assign y1     = r_y + 1'b1;
    assign y_m1   = r_y - 1'b1;
    assign x_dec  = r_x - 1'b1;
    assign x_aft  = cond ? x_dec : r_x;
    assign take_b = cond && room1;

    assign cmp_a  = (SW+1)'(x_aft) - (SW+1)'(y1);
    assign cmp_b  = (SW+1)'(x_dec) - (SW+1)'(r_y);
    assign a_last = !take_b && !(!cmp_a[SW] && room1);
    assign b_last = !(!cmp_b[SW] && room1);

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_sts.out_free = out_free;
    assign o_sts.take_b   = take_b;
    assign o_sts.a_last   = a_last;
    assign o_sts.b_last   = b_last;

    // Span pair: first kind uses row offset y and half width x, second x and y - 1.
    assign dyw  = i_cmd.emit_b ? r_xw : r_yw;
    assign half = i_cmd.emit_b ? y_m1 : r_x;
    assign col  = AW'(r_cx) - AW'(half);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= fdsg_pkg::WIDTH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_width <= i_cfg_wdata;
            end
            if (i_cmd.emit_a || i_cmd.emit_b) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx    <= i_center_x[CW-1:0];
            r_cy    <= i_center_y[CW-1:0];
            r_color <= i_fill_color;
            r_x     <= SW'(rad_sat);
            r_y     <= '0;
            r_err   <= '0;
            r_n     <= '0;
            r_yw    <= '0;
        end
        if (i_cmd.mul_c) begin
            r_base <= mul_ext;
        end
        if (i_cmd.mul_r) begin
            r_xw <= mul_ext;
        end
        if (i_cmd.emit_a) begin
            r_y  <= y1;
            r_yw <= r_yw + w_ext;
            r_n  <= n1;
            // Without room for the mirrored pair, step x here.
            if (cond && !take_b) begin
                r_x   <= x_dec;
                r_xw  <= r_xw - w_ext;
                r_err <= e_dec;
            end else begin
                r_err <= e1;
            end
        end
        if (i_cmd.emit_b) begin
            r_x   <= x_dec;
            r_xw  <= r_xw - w_ext;
            r_err <= e_b;
            r_n   <= n1;
        end
        if (i_cmd.emit_a || i_cmd.emit_b) begin
            r_upper     <= r_base - dyw + col;
            r_lower     <= r_base + dyw + col;
            r_len       <= i_cmd.emit_b ? LW'({y_m1, 1'b0}) : LW'({r_x, 1'b0});
            r_out_color <= r_color;
            r_last      <= i_cmd.emit_b ? b_last : a_last;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_upper_start_address = signed'(r_upper);
    assign o_lower_start_address = signed'(r_lower);
    assign o_span_length         = r_len;
    assign o_span_color          = r_out_color;
    assign o_last_span           = r_last;

endmodule

// ===== src/fdsg_ctrl.sv =====
// Controller: sequences request load, row products and span pair emission.
`timescale 1ns / 1ps

module fdsg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  fdsg_pkg::t_sts i_sts,
    output fdsg_pkg::t_cmd o_cmd,
    output logic           o_busy
);

    fdsg_pkg::t_state r_state;
    fdsg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fdsg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            fdsg_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = fdsg_pkg::ST_MUL_C;
                end
            end
            fdsg_pkg::ST_MUL_C: begin
                o_cmd.mul_c = 1'b1;
                n_state     = fdsg_pkg::ST_MUL_R;
            end
            fdsg_pkg::ST_MUL_R: begin
                o_cmd.mul_r = 1'b1;
                n_state     = fdsg_pkg::ST_EMIT_A;
            end
            fdsg_pkg::ST_EMIT_A: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_a = 1'b1;
                    priority if (i_sts.take_b) begin
                        n_state = fdsg_pkg::ST_EMIT_B;
                    end else if (i_sts.a_last) begin
                        n_state = fdsg_pkg::ST_IDLE;
                    end else begin
                        n_state = fdsg_pkg::ST_EMIT_A;
                    end
                end
            end
            fdsg_pkg::ST_EMIT_B: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_b = 1'b1;
                    n_state      = i_sts.b_last ? fdsg_pkg::ST_IDLE : fdsg_pkg::ST_EMIT_A;
                end
            end
            default: begin
                n_state = fdsg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
